/* rtl/chs_transfer_splitter_defines.svh */
// ----------------------------------------------------------------------------
// CHS transfer splitter assertion macros
// Shared property forms for the splitter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CHS_TRANSFER_SPLITTER_DEFINES_SVH
`define CHS_TRANSFER_SPLITTER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CHS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define CHS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/chs_ts_pkg.sv */
// ----------------------------------------------------------------------------
// CHS transfer splitter package
// Request and chunk operation codes, register map and reset values.
// ----------------------------------------------------------------------------
package chs_ts_pkg;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_WVERIFY = 2'd2,
    OP_RVERIFY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    FN_READ   = 2'd0,
    FN_WRITE  = 2'd1,
    FN_VERIFY = 2'd2
  } fn_e;

  // register word index (paddr[4:2])
  localparam logic [2:0] RegSpt = 3'd0;
  localparam logic [2:0] RegNh  = 3'd1;
  localparam logic [2:0] RegLog = 3'd2;
  localparam logic [2:0] RegSpb = 3'd3;
  localparam logic [2:0] RegRbr = 3'd4;

  localparam logic [5:0] SptReset = 6'd18;
  localparam logic [4:0] NhReset  = 5'd2;
  localparam logic [7:0] SpbReset = 8'd18;

  // restoring divider steps, one per dividend bit
  localparam logic [3:0] DivSteps = 4'd10;

endpackage

/* rtl/chs_transfer_splitter.sv */
// ----------------------------------------------------------------------------
// CHS transfer splitter
// Cuts a CHS disk request into chunk commands and tracks completions.
// ----------------------------------------------------------------------------
// Flow: a start word passes check, limit and result (a zero count goes
// straight to result, bad geometry skips limit); a completion that ends,
// passes or reissues goes straight to result; one that advances the address
// first makes two passes of the shared restoring divider, then check, limit,
// result. in_ready_o is low until the result enters the output register
// once it is free. Reset (rst_ni low, async): geometry 18/2/0/18/0, idle.
// ----------------------------------------------------------------------------
`include "chs_transfer_splitter_defines.svh"

module chs_transfer_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [1:0]  op_i,
  input  logic [9:0]  start_cylinder_i,
  input  logic [3:0]  start_head_i,
  input  logic [5:0]  start_sector_i,
  input  logic [15:0] block_count_i,
  input  logic        chunk_ok_i,
  input  logic        readback_mismatch_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        issue_o,
  output logic [1:0]  function_res_o,
  output logic [9:0]  cylinder_o,
  output logic [3:0]  head_o,
  output logic [5:0]  sector_o,
  output logic [9:0]  sector_count_o,
  output logic [15:0] blocks_done_o,
  output logic        finished_o,
  output logic        failed_o
);

  import chs_ts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_S,
    ST_DIV_T,
    ST_CHECK,
    ST_LIMIT,
    ST_RESULT
  } state_e;

  // configuration registers
  logic [5:0] spt_q;
  logic [4:0] nh_q;
  logic       log_q;
  logic [7:0] spb_q;
  logic       rbr_q;

  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q <= SptReset;
      nh_q  <= NhReset;
      log_q <= 1'b0;
      spb_q <= SpbReset;
      rbr_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        RegSpt:  spt_q <= pwdata[5:0];
        RegNh:   nh_q  <= pwdata[4:0];
        RegLog:  log_q <= pwdata[0];
        RegSpb:  spb_q <= pwdata[7:0];
        RegRbr:  rbr_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegSpt:  prdata = {26'd0, spt_q};
      RegNh:   prdata = {27'd0, nh_q};
      RegLog:  prdata = {31'd0, log_q};
      RegSpb:  prdata = {24'd0, spb_q};
      RegRbr:  prdata = {31'd0, rbr_q};
      default: prdata = 32'd0;
    endcase
  end

  // request state
  state_e      state_q, state_d;
  logic        busy_q, busy_d;
  op_e         op_q, op_d;
  fn_e         fn_q, fn_d;
  logic [9:0]  cyl_q, cyl_d;
  logic [3:0]  head_q, head_d;
  logic [5:0]  sec_q, sec_d;
  logic [15:0] total_q, total_d;
  logic [15:0] done_q, done_d;
  logic [9:0]  chunk_q, chunk_d;
  logic [10:0] lim_q, lim_d;
  // shared divider
  logic [5:0]  rem_q, rem_d;
  logic [9:0]  quo_q, quo_d;
  logic [5:0]  dvs_q, dvs_d;
  logic [3:0]  cnt_q, cnt_d;
  // pending result flags
  logic        rissue_q, rissue_d;
  logic        rfin_q, rfin_d;
  logic        rfail_q, rfail_d;
  // output register
  logic        ov_q, ov_d;
  logic        oissue_q, oissue_d;
  logic [1:0]  ofn_q, ofn_d;
  logic [9:0]  ocyl_q, ocyl_d;
  logic [3:0]  ohead_q, ohead_d;
  logic [5:0]  osec_q, osec_d;
  logic [9:0]  ocnt_q, ocnt_d;
  logic [15:0] odone_q, odone_d;
  logic        ofin_q, ofin_d;
  logic        ofail_q, ofail_d;

  logic        in_acc;
  logic [15:0] done_sum;
  logic [6:0]  trial;
  logic        trial_ge;
  logic [6:0]  trial_sub;
  logic        geo_bad;
  logic [4:0]  hd_left;
  logic [10:0] prod;
  logic [10:0] span;
  logic [15:0] left;
  logic [10:0] lim_buf;
  logic [15:0] lim_fin;
  logic        step_done;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  always_comb begin
    state_d  = state_q;
    busy_d   = busy_q;
    op_d     = op_q;
    fn_d     = fn_q;
    cyl_d    = cyl_q;
    head_d   = head_q;
    sec_d    = sec_q;
    total_d  = total_q;
    done_d   = done_q;
    chunk_d  = chunk_q;
    lim_d    = lim_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dvs_d    = dvs_q;
    cnt_d    = cnt_q;
    rissue_d = rissue_q;
    rfin_d   = rfin_q;
    rfail_d  = rfail_q;
    ov_d     = ov_q & ~out_ready_i;
    oissue_d = oissue_q;
    ofn_d    = ofn_q;
    ocyl_d   = ocyl_q;
    ohead_d  = ohead_q;
    osec_d   = osec_q;
    ocnt_d   = ocnt_q;
    odone_d  = odone_q;
    ofin_d   = ofin_q;
    ofail_d  = ofail_q;
    step_done = 1'b1;

    done_sum  = done_q + {6'd0, chunk_q};
    trial     = {rem_q, quo_q[9]};
    trial_ge  = (trial >= {1'b0, dvs_q});
    trial_sub = trial - {1'b0, dvs_q};
    geo_bad   = (spt_q == 6'd0) || (nh_q == 5'd0) || (nh_q > 5'd16) ||
                (sec_q == 6'd0) || (sec_q > spt_q) || ({1'b0, head_q} >= nh_q);
    hd_left   = nh_q - {1'b0, head_q};
    prod      = {6'd0, hd_left} * {5'd0, spt_q};
    span      = log_q ? ({5'd0, spt_q} + 11'd1 - {5'd0, sec_q})
                      : (prod + 11'd1 - {5'd0, sec_q});
    left      = total_q - done_q;
    lim_buf   = (lim_q > {3'd0, spb_q}) ? {3'd0, spb_q} : lim_q;
    lim_fin   = ({5'd0, lim_buf} > left) ? left : {5'd0, lim_buf};

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RESULT;
          if (!cmd_i) begin
            op_d    = op_e'(op_i);
            cyl_d   = start_cylinder_i;
            head_d  = start_head_i;
            sec_d   = start_sector_i;
            total_d = block_count_i;
            done_d  = 16'd0;
            chunk_d = 10'd0;
            busy_d  = 1'b1;
            if (block_count_i == 16'd0) begin
              busy_d   = 1'b0;
              rissue_d = 1'b0;
              rfin_d   = 1'b1;
              rfail_d  = 1'b0;
            end else begin
              state_d = ST_CHECK;
            end
          end else if (!busy_q) begin
            // completion with no request: report only the done count
            rissue_d = 1'b0;
            rfin_d   = 1'b0;
            rfail_d  = 1'b0;
          end else begin
            if (op_q == OP_WVERIFY && chunk_ok_i) begin
              if (fn_q == FN_WRITE) begin
                fn_d      = rbr_q ? FN_READ : FN_VERIFY;
                step_done = 1'b0;
              end else begin
                // read-back mismatch reissues the same write
                if (fn_q == FN_READ && readback_mismatch_i) begin
                  step_done = 1'b0;
                end
                fn_d = FN_WRITE;
              end
            end
            if (!step_done) begin
              rissue_d = 1'b1;
              rfin_d   = 1'b0;
              rfail_d  = 1'b0;
            end else begin
              done_d   = done_sum;
              rissue_d = 1'b0;
              rfin_d   = 1'b1;
              if (!chunk_ok_i) begin
                busy_d  = 1'b0;
                rfail_d = 1'b1;
              end else if (done_sum >= total_q) begin
                busy_d  = 1'b0;
                rfail_d = 1'b0;
              end else if (spt_q == 6'd0 || nh_q == 5'd0) begin
                busy_d  = 1'b0;
                rfail_d = 1'b1;
              end else begin
                // advance: split sector offset into tracks and sector
                rem_d   = 6'd0;
                quo_d   = {4'd0, sec_q} - 10'd1 + chunk_q;
                dvs_d   = spt_q;
                cnt_d   = DivSteps;
                state_d = ST_DIV_S;
              end
            end
          end
        end
      end

      ST_DIV_S, ST_DIV_T: begin
        if (cnt_q != 4'd0) begin
          cnt_d = cnt_q - 4'd1;
          if (trial_ge) begin
            rem_d = trial_sub[5:0];
            quo_d = {quo_q[8:0], 1'b1};
          end else begin
            rem_d = trial[5:0];
            quo_d = {quo_q[8:0], 1'b0};
          end
        end else if (state_q == ST_DIV_S) begin
          sec_d   = rem_q + 6'd1;
          rem_d   = 6'd0;
          quo_d   = {6'd0, head_q} + quo_q;
          dvs_d   = {1'b0, nh_q};
          cnt_d   = DivSteps;
          state_d = ST_DIV_T;
        end else begin
          cyl_d   = cyl_q + quo_q;
          head_d  = rem_q[3:0];
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (geo_bad) begin
          busy_d   = 1'b0;
          rissue_d = 1'b0;
          rfin_d   = 1'b1;
          rfail_d  = 1'b1;
          state_d  = ST_RESULT;
        end else begin
          lim_d   = span;
          state_d = ST_LIMIT;
        end
      end

      ST_LIMIT: begin
        state_d = ST_RESULT;
        if (lim_fin == 16'd0) begin
          busy_d   = 1'b0;
          rissue_d = 1'b0;
          rfin_d   = 1'b1;
          rfail_d  = 1'b1;
        end else begin
          chunk_d = lim_fin[9:0];
          case (op_q)
            OP_READ:    fn_d = FN_READ;
            OP_RVERIFY: fn_d = FN_VERIFY;
            default:    fn_d = FN_WRITE;
          endcase
          rissue_d = 1'b1;
          rfin_d   = 1'b0;
          rfail_d  = 1'b0;
        end
      end

      ST_RESULT: begin
        // hold until the output register frees up
        if (!ov_q || out_ready_i) begin
          ov_d     = 1'b1;
          oissue_d = rissue_q;
          ofn_d    = rissue_q ? fn_q : 2'd0;
          ocyl_d   = rissue_q ? cyl_q : 10'd0;
          ohead_d  = rissue_q ? head_q : 4'd0;
          osec_d   = rissue_q ? sec_q : 6'd0;
          ocnt_d   = rissue_q ? chunk_q : 10'd0;
          odone_d  = done_q;
          ofin_d   = rfin_q;
          ofail_d  = rfail_q;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      busy_q   <= 1'b0;
      op_q     <= OP_READ;
      fn_q     <= FN_READ;
      cyl_q    <= 10'd0;
      head_q   <= 4'd0;
      sec_q    <= 6'd1;
      total_q  <= 16'd0;
      done_q   <= 16'd0;
      chunk_q  <= 10'd0;
      cnt_q    <= 4'd0;
      rissue_q <= 1'b0;
      rfin_q   <= 1'b0;
      rfail_q  <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      busy_q   <= busy_d;
      op_q     <= op_d;
      fn_q     <= fn_d;
      cyl_q    <= cyl_d;
      head_q   <= head_d;
      sec_q    <= sec_d;
      total_q  <= total_d;
      done_q   <= done_d;
      chunk_q  <= chunk_d;
      cnt_q    <= cnt_d;
      rissue_q <= rissue_d;
      rfin_q   <= rfin_d;
      rfail_q  <= rfail_d;
      ov_q     <= ov_d;
    end
  end

  // datapath and output payload, no reset needed
  always_ff @(posedge clk_i) begin
    lim_q    <= lim_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    dvs_q    <= dvs_d;
    oissue_q <= oissue_d;
    ofn_q    <= ofn_d;
    ocyl_q   <= ocyl_d;
    ohead_q  <= ohead_d;
    osec_q   <= osec_d;
    ocnt_q   <= ocnt_d;
    odone_q  <= odone_d;
    ofin_q   <= ofin_d;
    ofail_q  <= ofail_d;
  end

  assign out_valid_o    = ov_q;
  assign issue_o        = oissue_q;
  assign function_res_o = ofn_q;
  assign cylinder_o     = ocyl_q;
  assign head_o         = ohead_q;
  assign sector_o       = osec_q;
  assign sector_count_o = ocnt_q;
  assign blocks_done_o  = odone_q;
  assign finished_o     = ofin_q;
  assign failed_o       = ofail_q;

  `CHS_ASSERT_IMP(a_idle_fields_zero, out_valid_o && !issue_o,
                  sector_o == 6'd0 && sector_count_o == 10'd0 && cylinder_o == 10'd0,
                  "result without command carries chunk fields")
  `CHS_ASSERT_IMP(a_issue_nonempty, out_valid_o && issue_o,
                  sector_count_o != 10'd0 && sector_count_o <= 10'd255 && !finished_o,
                  "issued chunk has bad length or ends request")
  `CHS_ASSERT_IMP(a_fail_ends, out_valid_o && failed_o, finished_o,
                  "failed result does not end the request")
  `CHS_ASSERT_NXT(a_accept_busy, in_valid_i && in_ready_o, !in_ready_o,
                  "accepted word did not occupy the sequencer")
  `CHS_ASSERT_IMP(a_div_busy, state_q == ST_DIV_S || state_q == ST_DIV_T,
                  busy_q && cnt_q <= DivSteps,
                  "divider running outside a live request")

endmodule
